/* rtl/core/q16_16_fixed_point_alu_defines.svh */
// ----------------------------------------------------------------------------
// q16_16_fixed_point_alu_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef Q16_16_FIXED_POINT_ALU_DEFINES_SVH
`define Q16_16_FIXED_POINT_ALU_DEFINES_SVH

// same-cycle implication
`define Q16_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("q16 alu assertion failed");

// next-cycle implication
`define Q16_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("q16 alu assertion failed");

`endif

/* rtl/core/q16alu_pkg.sv */
// ----------------------------------------------------------------------------
// q16alu_pkg
// Opcodes and fixed widths of the Q16.16 arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package q16alu_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W  = 3;
	localparam int DIV_BPS = 2;	// quotient bits per divider stage

	typedef enum logic [CMD_W-1:0] {
		CMD_MUL   = 3'd0,
		CMD_DIV   = 3'd1,
		CMD_SIGN  = 3'd2,
		CMD_FLOOR = 3'd3,
		CMD_CEIL  = 3'd4,
		CMD_ROUND = 3'd5,
		CMD_ABS   = 3'd6
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/core/q16_16_fixed_point_alu.sv */
// Signed fixed-point ALU (Q16.16 by default): multiply, divide, sign, floor,
// ceil, round and abs. One request is accepted every cycle unless the pipe is
// full and the output stalls, and results leave in order. The pipeline depth
// is set by the restoring divider array, which resolves two quotient bits per
// pipeline stage; every operation travels the same pipeline. Divide by zero
// returns zero with divide_by_zero set.
// ----------------------------------------------------------------------------
// q16_16_fixed_point_alu
// Deep pipeline with per-stage valid bits and a ready chain.
// ----------------------------------------------------------------------------
`default_nettype none

module q16_16_fixed_point_alu #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [q16alu_pkg::CMD_W-1:0]    cmd,
	input  wire logic signed [q16alu_pkg::DATA_W-1:0] operand_a,
	input  wire logic signed [q16alu_pkg::DATA_W-1:0] operand_b,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [q16alu_pkg::DATA_W-1:0] result,
	output logic                                 divide_by_zero
);
	import q16alu_pkg::*;

	localparam int QB = DATA_W + FRAC_BITS;			// quotient bits
	localparam int DS = (QB + DIV_BPS - 1) / DIV_BPS;	// divider stages
	localparam int L  = DS + 2;
	localparam logic [DATA_W-1:0] FMASK = (DATA_W'(1) << FRAC_BITS) - DATA_W'(1);
	localparam logic [DATA_W-1:0] ONE   = DATA_W'(1) << FRAC_BITS;
	localparam logic [DATA_W-1:0] HALF  = DATA_W'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		cmd_t                    op;
		logic                    neg;
		logic                    dz;
		logic [DATA_W-1:0]       mag_b;
		logic [QB-1:0]           num;	// numerator bits out top, quotient in bottom
		logic [DATA_W-1:0]       rem;
		logic [2*DATA_W-1:0]     prod;
		logic [DATA_W-1:0]       res;
	} pipe_t;

	pipe_t data_s [L];
	pipe_t nxt    [L];
	logic  vld_s  [L];
	logic  en     [L];

	// ready chain: a stage moves when empty or when the next one moves
	assign en[L-1] = !vld_s[L-1] || out_ready;
	for (genvar i = 0; i < L-1; i++) begin : g_en
		assign en[i] = !vld_s[i] || en[i+1];
	end
	assign in_ready = en[0];

	// input stage: magnitudes, flags and all unary ops
	always_comb begin
		logic [DATA_W-1:0] a, mag_a, flr, frac;
		logic              up;
		a     = operand_a;
		mag_a = a[DATA_W-1] ? -a : a;
		flr   = a & ~FMASK;
		frac  = a & FMASK;
		up    = a[DATA_W-1] ? (frac > HALF) : (frac >= HALF);
		nxt[0].op    = cmd_t'(cmd);
		nxt[0].neg   = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
		nxt[0].dz    = (cmd_t'(cmd) == CMD_DIV) && (operand_b == '0);
		nxt[0].mag_b = operand_b[DATA_W-1] ? -operand_b : operand_b;
		nxt[0].num   = {mag_a, FRAC_BITS'(0)};
		nxt[0].rem   = '0;
		nxt[0].prod  = '0;
		unique case (cmd_t'(cmd))
			CMD_SIGN:  nxt[0].res = (a == '0) ? '0 : (a[DATA_W-1] ? '1 : DATA_W'(1));
			CMD_FLOOR: nxt[0].res = flr;
			CMD_CEIL:  nxt[0].res = (frac == '0) ? a : flr + ONE;
			CMD_ROUND: nxt[0].res = (a == '0) ? '0 : (up ? flr + ONE : flr);
			CMD_ABS:   nxt[0].res = mag_a;
			default:   nxt[0].res = '0;
		endcase
	end

	for (genvar i = 0; i < L-1; i++) begin : g_stage
		always_comb begin
			pipe_t                     s;
			logic [DATA_W:0]           t;
			logic signed [2*DATA_W-1:0] sp;
			s  = data_s[i];
			t  = '0;
			sp = '0;
			if (i < DS) begin
				for (int k = 0; k < DIV_BPS; k++) begin
					if (i*DIV_BPS + k < QB) begin
						t = {s.rem, s.num[QB-1]};
						if (t >= {1'b0, s.mag_b}) begin
							t = t - {1'b0, s.mag_b};
							s.num = {s.num[QB-2:0], 1'b1};
						end else begin
							s.num = {s.num[QB-2:0], 1'b0};
						end
						s.rem = t[DATA_W-1:0];
					end
				end
			end
			if (i == 0) begin
				s.prod = (2*DATA_W)'(data_s[i].num[QB-1 -: DATA_W]) *
					(2*DATA_W)'(data_s[i].mag_b);
			end
			if (i == 1 && data_s[i].op == CMD_MUL) begin
				sp = data_s[i].neg ? -$signed(data_s[i].prod) : $signed(data_s[i].prod);
				sp = sp >>> FRAC_BITS;
				s.res = sp[DATA_W-1:0];
			end
			if (i == L-2 && data_s[i].op == CMD_DIV) begin
				s.res = data_s[i].dz ? '0 :
					(data_s[i].neg ? -data_s[i].num[DATA_W-1:0] : data_s[i].num[DATA_W-1:0]);
			end
			nxt[i+1] = s;
		end
	end

	for (genvar i = 0; i < L; i++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en[i]) begin
				vld_s[i] <= (i == 0) ? in_valid : vld_s[(i == 0) ? 0 : i-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en[i]) begin
				data_s[i] <= nxt[i];
			end
		end
	end

	assign out_valid      = vld_s[L-1];
	assign result         = data_s[L-1].res;
	assign divide_by_zero = data_s[L-1].dz;

endmodule

`default_nettype wire

/* rtl/core/q16alu_checker.sv */
// ----------------------------------------------------------------------------
// q16alu_checker
// Port-level checks on the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "q16_16_fixed_point_alu_defines.svh"

module q16alu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] result,
	input wire logic        divide_by_zero
);
	// a zero divisor always yields a zero quotient
	`Q16_ASSERT_IMPLY(a_dz_zero, clk, arst_n, out_valid && divide_by_zero, result == '0)
	// input backs up only when the whole pipe is full and output stalls
	`Q16_ASSERT_IMPLY(a_bp_src, clk, arst_n, !in_ready, out_valid && !out_ready)
	`Q16_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(result) && $stable(divide_by_zero))

endmodule

bind q16_16_fixed_point_alu q16alu_checker u_q16alu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.result         (result),
	.divide_by_zero (divide_by_zero)
);

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Q16.16 ALU: directed corner requests, then
// random traffic under several idle/stall phases, results checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class alu_scoreboard;
	logic [31:0] exp_result[$];
	logic        exp_dz[$];
	int          errors;

	function new();
		errors = 0;
	endfunction

	// arithmetic shift of the full product, low word kept
	static function logic [31:0] q_mul(logic [31:0] a, logic [31:0] b);
		logic signed [63:0] p;
		p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
		p = p >>> 16;
		return p[31:0];
	endfunction

	static function logic [31:0] q_div(logic [31:0] a, logic [31:0] b);
		logic [63:0] ma, mb, q;
		ma = a[31] ? {32'd0, -a} : {32'd0, a};
		mb = b[31] ? {32'd0, -b} : {32'd0, b};
		q = (ma << 16) / mb;
		if (a[31] != b[31])
			q = -q;
		return q[31:0];
	endfunction

	function void note_request(logic [2:0] op, logic [31:0] a, logic [31:0] b);
		logic [31:0] r;
		logic        dz;
		logic [15:0] fr;
		r = '0;
		dz = 1'b0;
		fr = a[15:0];
		case (op)
			q16alu_pkg::CMD_MUL: r = q_mul(a, b);
			q16alu_pkg::CMD_DIV: begin
				if (b == 0)
					dz = 1'b1;
				else
					r = q_div(a, b);
			end
			q16alu_pkg::CMD_SIGN: r = (a == 0) ? 32'd0 : (a[31] ? 32'hffffffff : 32'd1);
			q16alu_pkg::CMD_FLOOR: r = a & 32'hffff0000;
			q16alu_pkg::CMD_CEIL: r = (fr == 0) ? a : (a & 32'hffff0000) + 32'h10000;
			q16alu_pkg::CMD_ROUND: begin
				if (a[31] ? (fr > 16'h8000) : (fr >= 16'h8000))
					r = (a & 32'hffff0000) + 32'h10000;
				else
					r = a & 32'hffff0000;
			end
			q16alu_pkg::CMD_ABS: r = a[31] ? -a : a;
			default: r = '0;
		endcase
		exp_result.push_back(r);
		exp_dz.push_back(dz);
	endfunction

	function void check_result(logic [31:0] r, logic dz);
		logic [31:0] er;
		logic        ed;
		if (exp_result.size() == 0) begin
			$error("unexpected result %h", r);
			errors++;
			return;
		end
		er = exp_result.pop_front();
		ed = exp_dz.pop_front();
		if (r !== er) begin
			$error("result: expected %h actual %h", er, r);
			errors++;
		end
		if (dz !== ed) begin
			$error("divide_by_zero: expected %b actual %b", ed, dz);
			errors++;
		end
	endfunction
endclass

module tb;
	import q16alu_pkg::*;

	localparam int LATENCY = 26;
	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  cmd;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic        out_valid;
	logic        out_ready;
	logic signed [31:0] result;
	logic        divide_by_zero;

	alu_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	bit hold_off;
	int quiet_cycles;

	q16_16_fixed_point_alu uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.result(result), .divide_by_zero(divide_by_zero)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: check on handshake, pick next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(result, divide_by_zero);
		if (!arst_n || hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(7))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return {16'($urandom_range(65535)), 16'h0000};
			3: return {16'($urandom()), 16'h8000};
			4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			5: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
			default: return $urandom();
		endcase
	endfunction

	// valid stays high into the next request; it drops only while idling
	task automatic send_request(logic [2:0] op, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(op, a, b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.exp_result.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(int n, int idle, int stall);
		logic [2:0] op;
		logic [31:0] b;
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (n) begin
			op = 3'($urandom_range(7));
			b = ($urandom_range(15) == 0) ? 32'd0 : rand_operand();
			send_request(op, rand_operand(), b);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = '0;
		operand_a = '0;
		operand_b = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off = 1'b0;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: every op, extremes, zero divisor, halves, whole values
		send_request(CMD_MUL, 32'h7fffffff, 32'h7fffffff);
		send_request(CMD_MUL, 32'h80000000, 32'h80000000);
		send_request(CMD_MUL, 32'hffffffff, 32'h00000001);
		send_request(CMD_DIV, 32'h00010000, 32'd0);
		send_request(CMD_DIV, 32'h80000000, 32'hffffffff);
		send_request(CMD_DIV, 32'hfffe8000, 32'h00030000);
		send_request(CMD_SIGN, 32'd0, 32'hffffffff);
		send_request(CMD_SIGN, 32'h80000000, 32'd0);
		send_request(CMD_SIGN, 32'h7fffffff, 32'd0);
		send_request(CMD_FLOOR, 32'hfffe8000, 32'd0);
		send_request(CMD_CEIL, 32'h00030000, 32'd0);
		send_request(CMD_CEIL, 32'h7fff0001, 32'd0);
		send_request(CMD_CEIL, 32'hfffe8000, 32'd0);
		send_request(CMD_ROUND, 32'h00018000, 32'd0);
		send_request(CMD_ROUND, 32'hfffe8000, 32'd0);
		send_request(CMD_ROUND, 32'h7fff8000, 32'd0);
		send_request(CMD_ROUND, 32'hfffe7fff, 32'd0);
		send_request(CMD_ABS, 32'h80000000, 32'd0);
		send_request(CMD_ABS, 32'hffff0000, 32'd0);
		send_request(3'd7, 32'h12345678, 32'd0);
		drain();

		random_phase(400, 0, 0);
		random_phase(300, 70, 0);
		random_phase(300, 0, 70);
		random_phase(300, 20, 20);

		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_phase(100, 0, 0);
		join
		drain();
		random_phase(250, 0, 0);

		drain();
		repeat (LATENCY * 2) @(posedge clk);
		if (sb.errors == 0 && sb.exp_result.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
